// ----- src/mhic_pkg.sv -----
// Shared types, constants and helpers for the magnetometer hard-iron calibration core.
// Used by every module of the block; depends on nothing else.
package mhic_pkg;

  localparam int unsigned AXES        = 3;
  localparam int unsigned NUM_SLOTS   = 3;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned GAIN_FRAC   = 12;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned PROD_W      = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned SHIFT_W     = PROD_W - GAIN_FRAC;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [GAIN_W-1:0] GAIN_RESET       = GAIN_W'(4096);
  localparam logic [TIME_W-1:0] CAL_WINDOW_RESET = TIME_W'(30000000);

  typedef enum logic [1:0] {
    REG_GAIN_X     = 2'd0,
    REG_GAIN_Y     = 2'd1,
    REG_GAIN_Z     = 2'd2,
    REG_CAL_WINDOW = 2'd3
  } reg_idx_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [AXES-1:0] axes_t;

  typedef struct packed {
    axes_t             scaled;
    logic [TIME_W-1:0] time_us;
    logic              start_cal;
  } item_t;

  typedef struct packed {
    axes_t mag;
    logic  cal_active;
    axes_t offset;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  localparam logic signed [SHIFT_W-1:0] SAT_MAX = 32767;
  localparam logic signed [SHIFT_W-1:0] SAT_MIN = -32768;

  function automatic sample_t sat16(input logic signed [SHIFT_W-1:0] v);
    sample_t r;
    if (v > SAT_MAX) begin
      r = sample_t'(SAT_MAX[SAMPLE_W-1:0]);
    end else if (v < SAT_MIN) begin
      r = sample_t'(SAT_MIN[SAMPLE_W-1:0]);
    end else begin
      r = sample_t'(v[SAMPLE_W-1:0]);
    end
    return r;
  endfunction

endpackage

// ----- src/magnetometer_hard_iron_calibration_core.sv -----
// Magnetometer hard-iron calibration core: APB registers, front, queue and back.
// An accepted sample request passes the front register, then the queue, then the output
// register of the back stage, which updates min/max/offset as it pops the item.
// Throughput: one sample per cycle while the queue has room; a full queue stalls the input.
// Reset: gains return to unity, window to 30000000 us, offsets and min/max to zero.
// Depends on mhic_pkg, mhic_front, mhic_fifo and mhic_back.
module magnetometer_hard_iron_calibration_core import mhic_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [15:0]    raw_x_i,
  input  logic signed [15:0]    raw_y_i,
  input  logic signed [15:0]    raw_z_i,
  input  logic [31:0]           time_us_i,
  input  logic                  start_cal_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [15:0]    mag_x_o,
  output logic signed [15:0]    mag_y_o,
  output logic signed [15:0]    mag_z_o,
  output logic                  cal_active_o,
  output logic signed [15:0]    offset_x_o,
  output logic signed [15:0]    offset_y_o,
  output logic signed [15:0]    offset_z_o
);

  logic [GAIN_W-1:0]         gain_q [NUM_SLOTS];
  logic [TIME_W-1:0]         cal_window_q;
  logic                      wr_en;
  reg_idx_e                  reg_idx;

  sample_t                   raw_all [NUM_SLOTS];
  sample_t                   mag_all [NUM_SLOTS];
  sample_t                   off_all [NUM_SLOTS];
  axes_t                     raw_lanes;
  logic [AXES-1:0][GAIN_W-1:0] gain_lanes;

  logic                      push;
  logic                      pop;
  item_t                     front_item;
  item_t                     head_item;
  fifo_status_t              fifo_status;
  result_t                   result;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        gain_q[i] <= GAIN_RESET;
      end
      cal_window_q <= CAL_WINDOW_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GAIN_X:     gain_q[0]    <= pwdata[GAIN_W-1:0];
        REG_GAIN_Y:     gain_q[1]    <= pwdata[GAIN_W-1:0];
        REG_GAIN_Z:     gain_q[2]    <= pwdata[GAIN_W-1:0];
        REG_CAL_WINDOW: cal_window_q <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN_X:     prdata = APB_DATA_W'(gain_q[0]);
      REG_GAIN_Y:     prdata = APB_DATA_W'(gain_q[1]);
      REG_GAIN_Z:     prdata = APB_DATA_W'(gain_q[2]);
      REG_CAL_WINDOW: prdata = APB_DATA_W'(cal_window_q);
      default:        prdata = '0;
    endcase
  end

  // lane mapping
  assign raw_all[0] = raw_x_i;
  assign raw_all[1] = raw_y_i;
  assign raw_all[2] = raw_z_i;

  for (genvar g = 0; g < AXES; g++) begin : g_in_lane
    assign raw_lanes[g]  = raw_all[g];
    assign gain_lanes[g] = gain_q[g];
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_out_slot
    if (g < AXES) begin : g_used
      assign mag_all[g] = result.mag[g];
      assign off_all[g] = result.offset[g];
    end else begin : g_unused
      assign mag_all[g] = '0;
      assign off_all[g] = '0;
    end
  end

  assign mag_x_o      = mag_all[0];
  assign mag_y_o      = mag_all[1];
  assign mag_z_o      = mag_all[2];
  assign offset_x_o   = off_all[0];
  assign offset_y_o   = off_all[1];
  assign offset_z_o   = off_all[2];
  assign cal_active_o = result.cal_active;

  mhic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_i       (raw_lanes),
    .time_us_i   (time_us_i),
    .start_cal_i (start_cal_i),
    .gain_i      (gain_lanes),
    .fifo_full_i (fifo_status.full),
    .push_o      (push),
    .item_o      (front_item)
  );

  mhic_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .head_o   (head_item),
    .status_o (fifo_status)
  );

  mhic_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_status_i (fifo_status),
    .head_i        (head_item),
    .pop_o         (pop),
    .cal_window_i  (cal_window_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_o      (result)
  );

  // the front only stalls on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> fifo_status.full)
    else $error("input stalled while queue has room");

  // a result only appears after an item left the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!fifo_status.empty))
    else $error("result without a queued item");

  // a taken result with nothing queued leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && fifo_status.empty) |=> !out_valid_o)
    else $error("result repeated");

endmodule

// ----- src/mhic_front.sv -----
// Front stage: accepts a sample request, applies the Q4.12 gains with saturation
// and holds the scaled item until the queue takes it. Depends on mhic_pkg.
module mhic_front import mhic_pkg::*; (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  axes_t                           raw_i,
  input  logic [TIME_W-1:0]               time_us_i,
  input  logic                            start_cal_i,
  input  logic [AXES-1:0][GAIN_W-1:0]     gain_i,
  input  logic                            fifo_full_i,
  output logic                            push_o,
  output item_t                           item_o
);

  logic             valid_q, valid_d;
  logic             load;
  item_t            item_q, item_d;
  logic signed [PROD_W-1:0] prod [AXES];

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    assign prod[g] = $signed(raw_i[g]) * $signed({1'b0, gain_i[g]});
    // floor shift by the fraction bits, then clamp to 16 bits
    assign item_d.scaled[g] = sat16(prod[g][PROD_W-1:GAIN_FRAC]);
  end

  assign item_d.time_us   = time_us_i;
  assign item_d.start_cal = start_cal_i;

  assign in_stall_o = valid_q && fifo_full_i;
  assign push_o     = valid_q && !fifo_full_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// ----- src/mhic_fifo.sv -----
// Short queue of scaled items between the front and back stages.
// Depends on mhic_pkg.
module mhic_fifo import mhic_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  item_t        item_i,
  input  logic         pop_i,
  output item_t        head_o,
  output fifo_status_t status_o
);

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  assign status_o.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- src/mhic_back.sv -----
// Back stage: min/max tracking, window timing, offset correction and the
// output register. Depends on mhic_pkg.
module mhic_back import mhic_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fifo_status_t      fifo_status_i,
  input  item_t             head_i,
  output logic              pop_o,
  input  logic [TIME_W-1:0] cal_window_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output result_t           result_o
);

  axes_t             offset_q, offset_d;
  axes_t             min_q, min_d;
  axes_t             max_q, max_d;
  logic              running_q, running_d;
  logic              seeded_q, seeded_d;
  logic [TIME_W-1:0] wstart_q, wstart_d;
  logic              out_valid_q, out_valid_d;
  result_t           result_q, result_d;

  logic              calibrating;
  logic              first;
  logic              in_window;
  logic [TIME_W-1:0] elapsed;
  sample_t           min_base, max_base;
  logic signed [SAMPLE_W:0] sum;
  logic signed [SAMPLE_W:0] diff;

  assign pop_o = !fifo_status_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    offset_d    = offset_q;
    min_d       = min_q;
    max_d       = max_q;
    running_d   = running_q;
    seeded_d    = seeded_q;
    wstart_d    = wstart_q;
    result_d    = result_q;
    min_base    = '0;
    max_base    = '0;
    sum         = '0;
    diff        = '0;
    calibrating = running_q || head_i.start_cal;
    first       = !seeded_q;
    wstart_d    = (calibrating && first) ? head_i.time_us : wstart_q;
    elapsed     = head_i.time_us - wstart_d;
    in_window   = elapsed < cal_window_i;

    if (pop_o) begin
      for (int i = 0; i < AXES; i++) begin
        if (calibrating) begin
          result_d.mag[i] = head_i.scaled[i];
        end else begin
          diff = {head_i.scaled[i][SAMPLE_W-1], head_i.scaled[i]}
               - {offset_q[i][SAMPLE_W-1], offset_q[i]};
          result_d.mag[i] = sat16(SHIFT_W'(diff));
        end
      end

      if (calibrating) begin
        if (in_window) begin
          running_d = 1'b1;
          seeded_d  = 1'b1;
          for (int i = 0; i < AXES; i++) begin
            min_base = first ? head_i.scaled[i] : min_q[i];
            max_base = first ? head_i.scaled[i] : max_q[i];
            min_d[i] = ($signed(head_i.scaled[i]) < $signed(min_base)) ?
                       head_i.scaled[i] : min_base;
            max_d[i] = ($signed(head_i.scaled[i]) > $signed(max_base)) ?
                       head_i.scaled[i] : max_base;
            sum = {min_d[i][SAMPLE_W-1], min_d[i]} + {max_d[i][SAMPLE_W-1], max_d[i]};
            // floor of the midpoint
            offset_d[i] = sum[SAMPLE_W:1];
          end
        end else begin
          running_d = 1'b0;
          seeded_d  = 1'b0;
        end
      end else begin
        wstart_d = wstart_q;
      end

      result_d.cal_active = running_d;
      result_d.offset     = offset_d;
    end else begin
      wstart_d = wstart_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      min_q       <= '0;
      max_q       <= '0;
      running_q   <= 1'b0;
      seeded_q    <= 1'b0;
      wstart_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      offset_q    <= offset_d;
      min_q       <= min_d;
      max_q       <= max_d;
      running_q   <= running_d;
      seeded_q    <= seeded_d;
      wstart_q    <= wstart_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

// ----- dv/mhic_tb_pkg.sv -----
// Scoreboard for the magnetometer hard-iron calibration core testbench.
// Predicts scaled, offset-corrected readings and calibration state per sample request.
// Depends on mhic_pkg for the sample, result and register types.
package mhic_tb_pkg;
  import mhic_pkg::*;

  class hard_iron_scoreboard;
    logic [15:0] gain [3];
    logic [31:0] window;
    sample_t     offset_q [3];
    sample_t     min_q [3];
    sample_t     max_q [3];
    bit          running;
    bit          seeded;
    logic [31:0] window_start;
    result_t     expected_readings [$];
    string       axis_tag [3] = '{"x", "y", "z"};
    int          errors;
    int          checked;
    int          windows_opened;

    function new();
      for (int a = 0; a < 3; a++) begin
        gain[a]     = GAIN_RESET;
        offset_q[a] = '0;
        min_q[a]    = '0;
        max_q[a]    = '0;
      end
      window         = CAL_WINDOW_RESET;
      running        = 1'b0;
      seeded         = 1'b0;
      window_start   = '0;
      errors         = 0;
      checked        = 0;
      windows_opened = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [31:0] value);
      case (idx)
        REG_GAIN_X:     gain[0] = value[15:0];
        REG_GAIN_Y:     gain[1] = value[15:0];
        REG_GAIN_Z:     gain[2] = value[15:0];
        REG_CAL_WINDOW: window  = value;
      endcase
    endfunction

    function sample_t clamp16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return sample_t'(v[15:0]);
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    // raw[0] is X, raw[2] is Z
    function void note_sample(axes_t raw, logic [31:0] now, logic start);
      sample_t     scaled [3];
      result_t     r;
      bit          calibrating;
      bit          first;
      logic [31:0] elapsed;
      longint      prod;
      if (start) running = 1'b1;
      calibrating = running;
      for (int a = 0; a < 3; a++) begin
        prod      = longint'($signed(raw[a])) * longint'(gain[a]);
        scaled[a] = clamp16(prod >>> GAIN_FRAC);
        r.mag[a]  = calibrating ? scaled[a]
                                : clamp16(longint'(scaled[a]) - longint'(offset_q[a]));
      end
      if (calibrating) begin
        first = !seeded;
        if (first) begin
          window_start = now;
          seeded       = 1'b1;
          windows_opened++;
        end
        elapsed = now - window_start;
        if (elapsed < window) begin
          for (int a = 0; a < 3; a++) begin
            if (first) begin
              min_q[a] = scaled[a];
              max_q[a] = scaled[a];
            end
            if (scaled[a] < min_q[a]) min_q[a] = scaled[a];
            if (scaled[a] > max_q[a]) max_q[a] = scaled[a];
            offset_q[a] = clamp16((longint'(min_q[a]) + longint'(max_q[a])) >>> 1);
          end
        end else begin
          // window closed: keep min, max and offset, reseed on the next start
          running = 1'b0;
          seeded  = 1'b0;
        end
      end
      for (int a = 0; a < 3; a++) r.offset[a] = offset_q[a];
      r.cal_active = running;
      expected_readings.push_back(r);
    endfunction

    task report_mismatch(string field, logic signed [31:0] got, logic signed [31:0] want);
      errors++;
      if (errors <= 40)
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_readings.size() == 0) begin
        report_mismatch("result with no sample pending", 0, 0);
        return;
      end
      want = expected_readings.pop_front();
      checked++;
      for (int a = 0; a < 3; a++) begin
        if (got.mag[a] !== want.mag[a])
          report_mismatch({"mag_", axis_tag[a]}, $signed(got.mag[a]), $signed(want.mag[a]));
        if (got.offset[a] !== want.offset[a])
          report_mismatch({"offset_", axis_tag[a]}, $signed(got.offset[a]),
                          $signed(want.offset[a]));
      end
      if (got.cal_active !== want.cal_active)
        report_mismatch("cal_active", got.cal_active, want.cal_active);
    endtask

    task check_drained();
      if (expected_readings.size() != 0)
        report_mismatch("results never delivered", expected_readings.size(), 0);
    endtask
  endclass

endpackage

// ----- dv/magnetometer_hard_iron_calibration_core_tb.sv -----
// Testbench for magnetometer_hard_iron_calibration_core: directed and random sample
// requests under several register settings, with random idling on both channels.
// Depends on mhic_pkg and mhic_tb_pkg.
module magnetometer_hard_iron_calibration_core_tb;
  import mhic_pkg::*;
  import mhic_tb_pkg::*;

  localparam int STALL_LIMIT     = 1000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int LONG_HOLD       = 64;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 325;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic signed [15:0]    raw_x_i;
  logic signed [15:0]    raw_y_i;
  logic signed [15:0]    raw_z_i;
  logic [31:0]           time_us_i;
  logic                  start_cal_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic signed [15:0]    mag_x_o;
  logic signed [15:0]    mag_y_o;
  logic signed [15:0]    mag_z_o;
  logic                  cal_active_o;
  logic signed [15:0]    offset_x_o;
  logic signed [15:0]    offset_y_o;
  logic signed [15:0]    offset_z_o;

  hard_iron_scoreboard sb = new();

  bit no_idle;
  bit rx_hold_req;
  int sent;
  int settings_applied;
  int idle_cycles;

  magnetometer_hard_iron_calibration_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .raw_x_i      (raw_x_i),
    .raw_y_i      (raw_y_i),
    .raw_z_i      (raw_z_i),
    .time_us_i    (time_us_i),
    .start_cal_i  (start_cal_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mag_x_o      (mag_x_o),
    .mag_y_o      (mag_y_o),
    .mag_z_o      (mag_z_o),
    .cal_active_o (cal_active_o),
    .offset_x_o   (offset_x_o),
    .offset_y_o   (offset_y_o),
    .offset_z_o   (offset_z_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one sample request and hold it until the block takes it.
  task automatic offer_sample(input sample_t x, input sample_t y, input sample_t z,
                              input logic [31:0] t, input logic st);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    raw_x_i     <= x;
    raw_y_i     <= y;
    raw_z_i     <= z;
    time_us_i   <= t;
    start_cal_i <= st;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sample({z, y, x}, t, st);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_register(idx, value);
  endtask

  task automatic apply_setting(input logic [15:0] gx, input logic [15:0] gy,
                               input logic [15:0] gz, input logic [31:0] win);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_register(REG_GAIN_X, {16'h0, gx});
    write_register(REG_GAIN_Y, {16'h0, gy});
    write_register(REG_GAIN_Z, {16'h0, gz});
    write_register(REG_CAL_WINDOW, win);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_applied++;
  endtask

  function automatic sample_t draw_axis();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] draw_gain(int kind);
    case (kind)
      0: return 16'($urandom_range(3000, 5500));
      1: return 16'($urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'd0;
          1:       return 16'd1;
          2:       return 16'd4096;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // Receiver: random stall before each result, one long hold-off on request.
  initial begin : receiver
    int gap;
    out_stall_i = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (rx_hold_req) begin
        gap         = LONG_HOLD;
        rx_hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    result_t observed;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      observed.mag        = {mag_z_o, mag_y_o, mag_x_o};
      observed.offset     = {offset_z_o, offset_y_o, offset_x_o};
      observed.cal_active = cal_active_o;
      sb.check_result(observed);
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
    $display("[magnetometer_hard_iron_calibration_core] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] cur_time;
    logic [31:0] win;
    logic [31:0] windows [PHASES];
    int          step_max;
    int          directed;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    raw_x_i     = '0;
    raw_y_i     = '0;
    raw_z_i     = '0;
    time_us_i   = '0;
    start_cal_i = 1'b0;
    no_idle     = 1'b0;
    rx_hold_req = 1'b0;
    sent        = 0;
    windows     = '{32'd200, 32'd1, 32'hFFFF_FFFF, 32'd5000, 32'd0, 32'd0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: unity gains, long window
    offer_sample(16'sh7FFF, 16'sh8000, 16'sd0, 32'd0, 1'b0);
    offer_sample(-16'sd1, 16'sd1, 16'sd12345, 32'd5, 1'b0);
    offer_sample(16'sd1000, -16'sd2000, 16'sd300, 32'd100, 1'b1);
    // start while running keeps the window open
    offer_sample(16'sd3000, 16'sd500, 16'sh8000, 32'd200, 1'b1);
    offer_sample(16'sh8000, 16'sh7FFF, 16'sh7FFF, 32'd300, 1'b0);
    offer_sample(16'sd7, 16'sd7, 16'sd7, 32'd30000100, 1'b0);
    // corrected values saturate against the fresh offsets
    offer_sample(16'sh7FFF, 16'sh8000, 16'sh8000, 32'd30000200, 1'b0);
    offer_sample(16'sd0, 16'sd0, 16'sd0, 32'd30000300, 1'b0);
    offer_sample(16'sd5, -16'sd5, 16'sd5, 32'd40000000, 1'b1);

    apply_setting(16'hFFFF, 16'd0, 16'd1, 32'd0);
    offer_sample(16'sh7FFF, 16'sh7FFF, -16'sd1, 32'd50, 1'b0);
    offer_sample(16'sh8000, 16'sh8000, 16'sd4095, 32'd55, 1'b0);
    // zero window closes on the first sample
    offer_sample(16'sd100, 16'sd100, 16'sd100, 32'd60, 1'b1);
    offer_sample(16'sd1, 16'sd1, 16'sd1, 32'd70, 1'b0);

    // window across the 32-bit time wrap, closing exactly at its length
    apply_setting(16'd0, 16'hFFFF, 16'd4096, 32'd1000);
    offer_sample(16'sd100, 16'sd200, 16'sd300, 32'hFFFF_FF00, 1'b1);
    offer_sample(-16'sd100, -16'sd200, -16'sd300, 32'h0000_0010, 1'b0);
    offer_sample(16'sd50, 16'sd60, 16'sd70, 32'h0000_02E7, 1'b0);
    offer_sample(16'sd9, 16'sd9, 16'sd9, 32'h0000_02E8, 1'b0);

    apply_setting(16'd4096, 16'd4096, 16'd4096, 32'hFFFF_FFFF);
    offer_sample(16'sd1234, -16'sd4321, 16'sd77, 32'h1234_5678, 1'b1);
    offer_sample(16'sd10, 16'sd20, 16'sd30, 32'h1234_5677, 1'b0);

    apply_setting(16'd4096, 16'd4096, 16'd4096, 32'd1);
    offer_sample(16'sd11, 16'sd22, 16'sd33, 32'd7, 1'b1);
    offer_sample(-16'sd11, -16'sd22, -16'sd33, 32'd7, 1'b0);
    offer_sample(16'sd44, 16'sd55, 16'sd66, 32'd8, 1'b0);
    directed = sent;

    for (int p = 0; p < PHASES; p++) begin
      win = (p == PHASES - 1) ? 32'($urandom_range(1, 3000)) : windows[p];
      apply_setting(draw_gain(p % 3), draw_gain(p % 3), draw_gain(p % 3), win);
      step_max = (win <= 32'd4000) ? int'(win / 4) + 2 : 1500;
      cur_time = $urandom;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // fill the block behind a long receiver hold-off
        if (p == 0 && k == 60) rx_hold_req = 1'b1;
        // pause until every pending result is back
        if (p == 1 && k == 150) wait_drained();
        no_idle = (k % 120 >= 96) || (p == 0 && k >= 60 && k < 100);
        if ($urandom_range(0, 39) == 0)
          cur_time = $urandom;
        else
          cur_time = cur_time + 32'($urandom_range(0, step_max));
        offer_sample(draw_axis(), draw_axis(), draw_axis(), cur_time,
                     $urandom_range(0, 11) == 0);
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES * 2) @(posedge clk_i);
    sb.check_drained();
    $display("covered %0d sample requests (%0d directed) over %0d register settings",
             sent, directed, settings_applied);
    $display("checked %0d results, %0d calibration windows opened, %0d mismatches",
             sb.checked, sb.windows_opened, sb.errors);
    if (sb.errors == 0) begin
      $display("[magnetometer_hard_iron_calibration_core] OK");
    end else begin
      $display("[magnetometer_hard_iron_calibration_core] ERROR");
    end
    $finish;
  end

endmodule
